>>> sv/les_pkg.sv
// line end splitter package: mode codes, byte constants and result types
// no dependencies
package les_pkg;

  localparam int unsigned ModeW = 3;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CntW  = 2;

  localparam logic [ModeW-1:0] MODE_LF    = 3'd0;
  localparam logic [ModeW-1:0] MODE_CR    = 3'd1;
  localparam logic [ModeW-1:0] MODE_CR_LF = 3'd2;
  localparam logic [ModeW-1:0] MODE_CRLF  = 3'd3;
  localparam logic [ModeW-1:0] MODE_AUTO  = 3'd4;

  localparam logic [ByteW-1:0] CHAR_LF = 8'h0a;
  localparam logic [ByteW-1:0] CHAR_CR = 8'h0d;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_EOL  = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] data_byte;
    logic             last_of_run;
  } res_t;

  typedef struct packed {
    logic [CntW-1:0] n;
    res_t            res0;
    res_t            res1;
    logic            after_cr_nxt;
  } dec_t;

endpackage

>>> sv/les_decode.sv
// classifies one byte under the current mode into zero, one or two results
// depends on les_pkg
module les_decode (
  input  logic [les_pkg::ModeW-1:0] mode,
  input  logic                      after_cr,
  input  logic [les_pkg::ByteW-1:0] char_in,
  output les_pkg::dec_t             dec
);
  import les_pkg::*;

  logic is_lf;
  logic is_cr;
  res_t eol_res;
  res_t chr_res;
  res_t cr_res;

  assign is_lf = (char_in == CHAR_LF);
  assign is_cr = (char_in == CHAR_CR);
  assign eol_res = '{kind: KIND_EOL, data_byte: '0, last_of_run: 1'b1};
  assign chr_res = '{kind: KIND_DATA, data_byte: char_in, last_of_run: 1'b1};
  assign cr_res  = '{kind: KIND_DATA, data_byte: CHAR_CR, last_of_run: 1'b1};

  always_comb begin
    dec = '{n: 2'd1, res0: chr_res, res1: chr_res, after_cr_nxt: 1'b0};
    unique case (mode)
      MODE_LF: begin
        if (is_lf) dec.res0 = eol_res;
      end
      MODE_CR: begin
        if (is_cr) dec.res0 = eol_res;
      end
      MODE_CR_LF: begin
        if (is_lf || is_cr) dec.res0 = eol_res;
      end
      MODE_CRLF: begin
        if (after_cr) begin
          if (is_lf) begin
            dec.res0 = eol_res;
          end else if (is_cr) begin
            dec.res0 = cr_res;
            dec.after_cr_nxt = 1'b1;
          end else begin
            dec.n = 2'd2;
            dec.res0 = cr_res;
            dec.res0.last_of_run = 1'b0;
          end
        end else if (is_cr) begin
          dec.n = 2'd0;
          dec.after_cr_nxt = 1'b1;
        end
      end
      default: begin
        if (is_lf) begin
          dec.res0 = eol_res;
          if (after_cr) dec.n = 2'd0;
        end else if (is_cr) begin
          dec.res0 = eol_res;
          dec.after_cr_nxt = 1'b1;
        end
      end
    endcase
  end

endmodule

>>> sv/les_queue.sv
// hold stage for up to two results of one byte plus the output register
// depends on les_pkg
module les_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  les_pkg::dec_t dec,
  output logic          load_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output les_pkg::res_t out_res
);
  import les_pkg::*;

  logic [CntW-1:0] hold_cnt_r, hold_cnt_nxt;
  res_t            hold0_r, hold0_nxt;
  res_t            hold1_r, hold1_nxt;
  logic            out_valid_r, out_valid_nxt;
  res_t            out_res_r, out_res_nxt;
  logic            move;

  assign move       = (hold_cnt_r != '0) && (!out_valid_r || out_ready);
  assign load_ready = (hold_cnt_r == '0) || ((hold_cnt_r == 2'd1) && move);

  always_comb begin
    hold_cnt_nxt  = hold_cnt_r;
    hold0_nxt     = hold0_r;
    hold1_nxt     = hold1_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (load) begin
      hold_cnt_nxt = dec.n;
      hold0_nxt    = dec.res0;
      hold1_nxt    = dec.res1;
    end else if (move) begin
      hold_cnt_nxt = hold_cnt_r - 2'd1;
      hold0_nxt    = hold1_r;
    end
    if (move) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = hold0_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      hold_cnt_r  <= hold_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    hold0_r   <= hold0_nxt;
    hold1_r   <= hold1_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

>>> sv/line_end_splitter_core.sv
// Line end splitter: takes one text byte per transfer and returns content bytes and
// line-end markers under the style in cfg_eol_mode (0 LF, 1 CR, 2 CR or LF, 3 CR LF,
// 4 to 7 auto). A byte is taken every cycle while the output is not stalled and each
// byte gives at most one result; a byte that gives two results (a held CR in CR LF mode
// followed by a byte other than CR or LF) holds the input back until its first result has
// moved on, since the output register moves one result per cycle. Results pass through the
// hold stage and then the output register. Writing the mode drops a held CR.
// depends on les_pkg, les_decode, les_queue
module line_end_splitter_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [les_pkg::ModeW-1:0] cfg_eol_mode,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [les_pkg::ByteW-1:0] in_char_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_kind,
  output logic [les_pkg::ByteW-1:0] out_data_byte,
  output logic                      out_last_of_run
);
  import les_pkg::*;

  logic [ModeW-1:0] mode_r, mode_nxt;
  logic             after_cr_r, after_cr_nxt;
  dec_t             dec;
  logic             load;
  res_t             out_res;

  les_decode u_decode (
    .mode     (mode_r),
    .after_cr (after_cr_r),
    .char_in  (in_char_in),
    .dec      (dec)
  );

  assign load = in_valid && in_ready;

  les_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .dec        (dec),
    .load_ready (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (out_res)
  );

  always_comb begin
    mode_nxt     = mode_r;
    after_cr_nxt = after_cr_r;
    if (cfg_we) begin
      mode_nxt     = cfg_eol_mode;
      after_cr_nxt = 1'b0;
    end else if (load) begin
      after_cr_nxt = dec.after_cr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_AUTO;
      after_cr_r <= 1'b0;
    end else begin
      mode_r     <= mode_nxt;
      after_cr_r <= after_cr_nxt;
    end
  end

  assign out_kind        = out_res.kind;
  assign out_data_byte   = out_res.data_byte;
  assign out_last_of_run = out_res.last_of_run;

endmodule

>>> test/tb_line_end_splitter_core.sv
// testbench for line_end_splitter_core: directed and random byte streams under every eol mode
// a scoreboard class predicts content bytes and line-end markers and checks each output transfer
// depends on les_pkg and line_end_splitter_core
module tb_line_end_splitter_core;
  import les_pkg::*;

  localparam int CycleLimit = 500000;
  localparam int MaxReports = 10;

  class eol_scoreboard;
    logic [ModeW-1:0] eol_mode;
    bit               cr_held;
    res_t             token_q[$];
    int               errors;

    function new();
      eol_mode = MODE_AUTO;
      cr_held  = 1'b0;
      errors   = 0;
    endfunction

    function void set_mode(logic [ModeW-1:0] m);
      eol_mode = m;
      cr_held  = 1'b0;
    endfunction

    function res_t make_token(logic kind, logic [ByteW-1:0] c);
      res_t r;
      r.kind        = kind;
      r.data_byte   = (kind == KIND_EOL) ? '0 : c;
      r.last_of_run = 1'b0;
      return r;
    endfunction

    function void note_byte(logic [ByteW-1:0] c);
      res_t             toks[$];
      logic [ModeW-1:0] m;
      m = (eol_mode > MODE_AUTO) ? MODE_AUTO : eol_mode;
      case (m)
        MODE_LF: begin
          cr_held = 1'b0;
          toks.push_back(make_token(c == CHAR_LF ? KIND_EOL : KIND_DATA, c));
        end
        MODE_CR: begin
          cr_held = 1'b0;
          toks.push_back(make_token(c == CHAR_CR ? KIND_EOL : KIND_DATA, c));
        end
        MODE_CR_LF: begin
          cr_held = 1'b0;
          toks.push_back(make_token((c == CHAR_LF || c == CHAR_CR) ? KIND_EOL : KIND_DATA, c));
        end
        MODE_CRLF: begin
          if (cr_held) begin
            if (c == CHAR_LF) begin
              cr_held = 1'b0;
              toks.push_back(make_token(KIND_EOL, '0));
            end else if (c == CHAR_CR) begin
              toks.push_back(make_token(KIND_DATA, CHAR_CR));
            end else begin
              cr_held = 1'b0;
              toks.push_back(make_token(KIND_DATA, CHAR_CR));
              toks.push_back(make_token(KIND_DATA, c));
            end
          end else if (c == CHAR_CR) begin
            cr_held = 1'b1;
          end else begin
            toks.push_back(make_token(KIND_DATA, c));
          end
        end
        default: begin
          if (c == CHAR_LF) begin
            if (!cr_held) toks.push_back(make_token(KIND_EOL, '0));
            cr_held = 1'b0;
          end else if (c == CHAR_CR) begin
            cr_held = 1'b1;
            toks.push_back(make_token(KIND_EOL, '0));
          end else begin
            cr_held = 1'b0;
            toks.push_back(make_token(KIND_DATA, c));
          end
        end
      endcase
      if (toks.size() > 0) toks[toks.size()-1].last_of_run = 1'b1;
      foreach (toks[i]) token_q.push_back(toks[i]);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (token_q.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("unexpected result: kind=%0d byte=%02h last=%0d",
                   got.kind, got.data_byte, got.last_of_run);
        return;
      end
      want = token_q.pop_front();
      if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
          got.last_of_run !== want.last_of_run) begin
        errors++;
        if (errors <= MaxReports)
          $display("mismatch: expected kind=%0d byte=%02h last=%0d, got kind=%0d byte=%02h last=%0d",
                   want.kind, want.data_byte, want.last_of_run,
                   got.kind, got.data_byte, got.last_of_run);
      end
    endfunction

    function int pending();
      return token_q.size();
    endfunction

    function void close_out();
      if (token_q.size() > 0) begin
        $display("%0d expected results never arrived", token_q.size());
        errors += token_q.size();
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [ModeW-1:0] cfg_eol_mode = MODE_AUTO;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [ByteW-1:0] in_char_in = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             out_kind;
  logic [ByteW-1:0] out_data_byte;
  logic             out_last_of_run;

  eol_scoreboard sb = new();
  int cycle_count = 0;
  int burst_left = 0;
  int stall_style = 0;
  int style_left = 0;
  int stall_left = 0;

  line_end_splitter_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_eol_mode    (cfg_eol_mode),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char_in      (in_char_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_data_byte   (out_data_byte),
    .out_last_of_run (out_last_of_run)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // transfers on both channels, sampled at the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        sb.check_result('{kind: out_kind, data_byte: out_data_byte, last_of_run: out_last_of_run});
      if (in_valid && in_ready)
        sb.note_byte(in_char_in);
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (style_left == 0) begin
      style_left  = $urandom_range(50, 300);
      stall_style = $urandom_range(0, 2);
    end
    style_left--;
    case (stall_style)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          out_ready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
          stall_left = $urandom_range(1, 12);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    endcase
  end

  task automatic send_char(input logic [ByteW-1:0] c);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
    end
    in_valid   <= 1'b1;
    in_char_in <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic send_seq(input logic [ByteW-1:0] s[$]);
    foreach (s[i]) send_char(s[i]);
  endtask

  // drain outputs, then allow for a held or swallowed byte still in the pipe
  task automatic wait_idle();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_mode(input logic [ModeW-1:0] m);
    wait_idle();
    cfg_we       <= 1'b1;
    cfg_eol_mode <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_mode(m);
  endtask

  task automatic send_text(input int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 15);
      if (r < 3) begin
        send_char(CHAR_CR);
      end else if (r < 6) begin
        send_char(CHAR_LF);
      end else if (r < 8) begin
        send_char(CHAR_CR);
        send_char(CHAR_LF);
        i++;
      end else if (r < 10) begin
        send_char(8'($urandom_range(0, 255)));
      end else begin
        send_char(8'($urandom_range(8'h20, 8'h7e)));
      end
    end
  endtask

  initial begin
    logic [ModeW-1:0] m;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // auto mode out of reset: swallowed lf after cr, lone lf, double cr, extremes
    send_seq('{8'h41, CHAR_CR, CHAR_LF, CHAR_LF, CHAR_CR, CHAR_CR, 8'h00, 8'hff});
    // cr lf mode: pair, lone cr before other byte, cr cr, held cr dropped by mode write
    write_mode(MODE_CRLF);
    send_seq('{8'h61, CHAR_CR, CHAR_LF, CHAR_CR, 8'h78, CHAR_CR, CHAR_CR, CHAR_LF, CHAR_CR});
    write_mode(MODE_LF);
    send_seq('{CHAR_CR, CHAR_LF});
    write_mode(MODE_CR);
    send_seq('{CHAR_LF, CHAR_CR});
    write_mode(MODE_CR_LF);
    send_seq('{CHAR_CR, CHAR_LF});
    write_mode(3'd7);
    send_seq('{CHAR_CR, CHAR_LF});

    for (int p = 0; p < 20; p++) begin
      m = (p < 8) ? ModeW'(p) : ModeW'($urandom_range(0, 7));
      write_mode(m);
      send_text(80);
    end

    wait_idle();
    repeat (10) @(posedge clk);
    sb.close_out();
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
